@@ hdl/bnd_pkg.sv @@
// types, register map and constants shared by the bivariate normal density block
package bnd_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // register indexes, byte address is four times the index
  localparam logic [2:0] REG_MEAN_FIRST  = 3'd0;
  localparam logic [2:0] REG_MEAN_SECOND = 3'd1;
  localparam logic [2:0] REG_INV_COV_00  = 3'd2;
  localparam logic [2:0] REG_INV_COV_01  = 3'd3;
  localparam logic [2:0] REG_INV_COV_10  = 3'd4;
  localparam logic [2:0] REG_INV_COV_11  = 3'd5;
  localparam logic [2:0] REG_NORM_SCALE  = 3'd6;

  localparam logic [31:0] RST_INV_COV_00 = 32'd65536;
  localparam logic [31:0] RST_INV_COV_11 = 32'd65536;
  localparam logic [31:0] RST_NORM_SCALE = 32'd10430;

  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [29:0] LN2_Q30   = 30'd744261118;
  localparam logic [30:0] ONE_Q30   = 31'd1073741824;
  // floor(x / 3) as (x * RECIP3) >> 20 for x below 2^19
  localparam logic [18:0] RECIP3    = 19'd349526;

  localparam logic [30:0] POW2_LUT [16] = '{
    31'd1073741824, 31'd1121280436, 31'd1170923762, 31'd1222764986,
    31'd1276901417, 31'd1333434672, 31'd1392470869, 31'd1454120821,
    31'd1518500250, 31'd1585730000, 31'd1655936265, 31'd1729250827,
    31'd1805811301, 31'd1885761398, 31'd1969251188, 31'd2056437387
  };

  typedef struct packed {
    logic signed [31:0] point_first;
    logic signed [31:0] point_second;
  } point_t;

  typedef struct packed {
    logic [31:0] density;
    logic        saturated;
  } result_t;

  typedef struct packed {
    logic signed [31:0] mean_first;
    logic signed [31:0] mean_second;
    logic signed [31:0] inv_cov_00;
    logic signed [31:0] inv_cov_01;
    logic signed [31:0] inv_cov_10;
    logic signed [31:0] inv_cov_11;
    logic        [31:0] norm_scale;
  } cfg_t;

endpackage

@@ hdl/bivariate_normal_density.sv @@
// bivariate normal density: each accepted request flows through the pipeline to its result
// one request accepted per cycle while point_ready is high, each stage holds one request in flight
// a stalled result stalls only the stages behind it, empty stages still fill
// the multiplier chain of the quadratic form and exp2 sets the depth
// synchronous rst clears the pipeline valid bits and restores register reset values
module bivariate_normal_density (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bnd_pkg::ADDR_W-1:0]  paddr,
  input  logic [bnd_pkg::DATA_W-1:0]  pwdata,
  output logic [bnd_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  input  logic                        point_valid,
  output logic                        point_ready,
  input  bnd_pkg::point_t             point,
  output logic                        result_valid,
  input  logic                        result_ready,
  output bnd_pkg::result_t            result
);
  import bnd_pkg::*;

  cfg_t       cfg;
  logic [2:0] ridx;
  logic       wr;

  assign pready = 1'b1;
  assign ridx = paddr[4:2];
  assign wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mean_first  <= '0;
      cfg.mean_second <= '0;
      cfg.inv_cov_00  <= RST_INV_COV_00;
      cfg.inv_cov_01  <= '0;
      cfg.inv_cov_10  <= '0;
      cfg.inv_cov_11  <= RST_INV_COV_11;
      cfg.norm_scale  <= RST_NORM_SCALE;
    end else if (wr) begin
      unique case (ridx)
        REG_MEAN_FIRST:  cfg.mean_first  <= pwdata;
        REG_MEAN_SECOND: cfg.mean_second <= pwdata;
        REG_INV_COV_00:  cfg.inv_cov_00  <= pwdata;
        REG_INV_COV_01:  cfg.inv_cov_01  <= pwdata;
        REG_INV_COV_10:  cfg.inv_cov_10  <= pwdata;
        REG_INV_COV_11:  cfg.inv_cov_11  <= pwdata;
        REG_NORM_SCALE:  cfg.norm_scale  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_MEAN_FIRST:  prdata = cfg.mean_first;
      REG_MEAN_SECOND: prdata = cfg.mean_second;
      REG_INV_COV_00:  prdata = cfg.inv_cov_00;
      REG_INV_COV_01:  prdata = cfg.inv_cov_01;
      REG_INV_COV_10:  prdata = cfg.inv_cov_10;
      REG_INV_COV_11:  prdata = cfg.inv_cov_11;
      REG_NORM_SCALE:  prdata = cfg.norm_scale;
      default:         prdata = '0;
    endcase
  end

  bnd_pipe u_pipe (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .point_valid  (point_valid),
    .point_ready  (point_ready),
    .point        (point),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

@@ hdl/bnd_pipe.sv @@
// datapath pipeline: quadratic form, exponent split, exp2 and output scaling
module bnd_pipe (
  input  logic            clk,
  input  logic            rst,
  input  bnd_pkg::cfg_t   cfg,
  input  logic            point_valid,
  output logic            point_ready,
  input  bnd_pkg::point_t point,
  output logic            result_valid,
  input  logic            result_ready,
  output bnd_pkg::result_t result
);
  import bnd_pkg::*;

  localparam int NS = 15;
  localparam int AW = 100;

  typedef struct packed {
    logic       kbig;
    logic       kzero;
    logic [5:0] shamt;
    logic [3:0] idx;
  } ctl_t;

  logic [NS:1] v;
  logic [NS:1] en;
  logic [NS:1] vin;

  // stage registers
  logic signed [32:0] d0, d1;
  logic signed [65:0] p00, p01, p11;
  logic signed [65:0] hh00, hh01, hh11;
  logic signed [66:0] lh00, lh01, lh11;
  logic signed [AW-1:0] t00, t01, t11;
  logic signed [AW-1:0] acc;
  logic signed [32:0] nq;
  logic signed [63:0] zp;
  ctl_t               ctl [8:14];
  logic [55:0]        tg;
  logic [25:0]        t_s9, t_s10, t_s11;
  logic [51:0]        t2p;
  logic [20:0]        t2_s10, t2_s11;
  logic [46:0]        t3p;
  logic [35:0]        t3q;
  logic [30:0]        poly;
  logic [61:0]        ep;
  logic [63:0]        prod;

  // combinational helpers
  logic signed [32:0]   moff;
  logic signed [AW-1:0] qs;
  logic signed [32:0]   nq_next;
  logic signed [63:0]   zs, kw, kdist;
  ctl_t                 ctl_next;
  logic [25:0]          t_cur;
  logic [20:0]          t2_cur;
  logic [64:0]          sval;
  logic [64:0]          shifted;
  result_t              result_next;

  localparam logic signed [AW-1:0] QMAX = AW'(64'sd2147483647);
  localparam logic signed [AW-1:0] QMIN = -AW'(64'sd2147483648);

  // flow control, a stage takes new data when empty or when it drains
  always_comb begin
    en[NS] = ~v[NS] | result_ready;
    for (int s = NS - 1; s >= 1; s--) begin
      en[s] = ~v[s] | en[s+1];
    end
  end

  assign vin = {v[NS-1:1], point_valid};
  assign point_ready = en[1];
  assign result_valid = v[NS];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int s = 1; s <= NS; s++) begin
        if (en[s]) begin
          v[s] <= vin[s];
        end
      end
    end
  end

  always_comb begin
    moff = cfg.inv_cov_01 + cfg.inv_cov_10;
    qs = acc >>> (2 * FRAC_BITS);
    if (qs > QMAX) begin
      nq_next = -33'sd2147483647;
    end else if (qs < QMIN) begin
      nq_next = 33'sd2147483648;
    end else begin
      nq_next = -33'(qs);
    end
    zs = zp >>> (FRAC_BITS + 1);
    kw = zs >>> 30;
    kdist = 64'sd31 - kw;
    ctl_next.kbig  = kw > 64'sd31;
    ctl_next.kzero = kdist > 64'sd63;
    ctl_next.shamt = kdist[5:0];
    ctl_next.idx   = zs[29:26];
    t_cur  = tg[55:30];
    t2_cur = t2p[51:31];
  end

  // stages 1 to 4: offsets, squares, partial products against the matrix
  always_ff @(posedge clk) begin
    if (en[1]) begin
      d0 <= point.point_first - cfg.mean_first;
      d1 <= point.point_second - cfg.mean_second;
    end
    if (en[2]) begin
      p00 <= d0 * d0;
      p01 <= d0 * d1;
      p11 <= d1 * d1;
    end
    if (en[3]) begin
      hh00 <= $signed(p00[65:33]) * 33'(cfg.inv_cov_00);
      hh01 <= $signed(p01[65:33]) * moff;
      hh11 <= $signed(p11[65:33]) * 33'(cfg.inv_cov_11);
      lh00 <= $signed({1'b0, p00[32:0]}) * 33'(cfg.inv_cov_00);
      lh01 <= $signed({1'b0, p01[32:0]}) * moff;
      lh11 <= $signed({1'b0, p11[32:0]}) * 33'(cfg.inv_cov_11);
    end
    if (en[4]) begin
      t00 <= (AW'(hh00) <<< 33) + AW'(lh00);
      t01 <= (AW'(hh01) <<< 33) + AW'(lh01);
      t11 <= (AW'(hh11) <<< 33) + AW'(lh11);
    end
  end

  // stages 5 to 8: sum, clamp, scale by log2(e), split exponent
  always_ff @(posedge clk) begin
    if (en[5]) begin
      acc <= t00 + t01 + t11;
    end
    if (en[6]) begin
      nq <= nq_next;
    end
    if (en[7]) begin
      zp <= nq * $signed({1'b0, LOG2E_Q30});
    end
    if (en[8]) begin
      ctl[8] <= ctl_next;
      tg     <= zs[25:0] * LN2_Q30;
    end
    for (int s = 9; s <= 14; s++) begin
      if (en[s]) begin
        ctl[s] <= ctl[s-1];
      end
    end
  end

  // stages 9 to 14: cubic for the low fraction, table, scale
  always_ff @(posedge clk) begin
    if (en[9]) begin
      t_s9 <= t_cur;
      t2p  <= t_cur * t_cur;
    end
    if (en[10]) begin
      t_s10  <= t_s9;
      t2_s10 <= t2_cur;
      t3p    <= t2_cur * t_s9;
    end
    if (en[11]) begin
      t_s11  <= t_s10;
      t2_s11 <= t2_s10;
      t3q    <= t3p[46:30] * RECIP3;
    end
    if (en[12]) begin
      poly <= ONE_Q30 + 31'(t_s11) + 31'(t2_s11) + 31'(t3q[35:20]);
    end
    if (en[13]) begin
      ep <= POW2_LUT[ctl[12].idx] * poly;
    end
    if (en[14]) begin
      prod <= cfg.norm_scale * ep[61:30];
    end
  end

  // stage 15: shift by the integer exponent, saturate
  always_comb begin
    sval = {prod, 1'b0};
    shifted = sval >> ctl[14].shamt;
    if (ctl[14].shamt == 6'd0) begin
      shifted[64] = 1'b0;
    end
    if (ctl[14].kbig) begin
      result_next.saturated = |cfg.norm_scale;
      result_next.density = result_next.saturated ? '1 : '0;
    end else if (ctl[14].kzero) begin
      result_next.saturated = 1'b0;
      result_next.density = '0;
    end else begin
      result_next.saturated = |shifted[63:32];
      result_next.density = result_next.saturated ? '1 : shifted[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[NS]) begin
      result <= result_next;
    end
  end

endmodule

@@ hdl/bnd_checker.sv @@
// port level checks for the density block, bound to the top level
module bnd_checker (
  input logic             clk,
  input logic             rst,
  input logic             pready,
  input logic             point_ready,
  input logic             result_valid,
  input logic             result_ready,
  input bnd_pkg::result_t result
);

  // a waiting result holds until taken
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // a clipped result always reads as all ones
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.saturated |-> result.density == 32'hFFFF_FFFF)
    else $error("saturated result not all ones");

  // reset empties the pipeline
  assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // an empty pipeline takes a request straight after reset
  assert property (@(posedge clk) rst |=> point_ready && pready)
    else $error("not ready after reset");

endmodule

bind bivariate_normal_density bnd_checker u_bnd_checker (.*);
